FILE: hdl/dtti_pkg.sv
`timescale 1ns / 1ps

package dtti_pkg;

  // Character classes decided in the front part.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_DIGIT = 2'd1;
  localparam logic [1:0] KIND_MINUS = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Largest magnitude that still takes another digit: (2^64-1) / 10 and its remainder.
  localparam logic [63:0] MAX_DIV10 = 64'd1844674407370955161;
  localparam logic [3:0]  MAX_MOD10 = 4'd5;

  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  localparam logic [1:0] WIDTH_SELECT_RST = WSEL_32;
  localparam logic       SIGNED_MODE_RST  = 1'b0;

  localparam logic REG_WIDTH_SELECT = 1'b0;
  localparam logic REG_SIGNED_MODE  = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] digit;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [63:0] magnitude;
    logic        failed;
    logic        negative;
    logic        seen_digit;
  } end_t;

endpackage

FILE: hdl/dtti_in_if.sv
`timescale 1ns / 1ps

interface dtti_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       last_char;

  modport source (output valid, char_code, has_char, last_char, input ready);
  modport sink (input valid, char_code, has_char, last_char, output ready);
endinterface

FILE: hdl/dtti_out_if.sv
`timescale 1ns / 1ps

interface dtti_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        ok;

  modport source (output valid, value, ok, input ready);
  modport sink (input valid, value, ok, output ready);
endinterface

FILE: hdl/dtti_fifo.sv
`timescale 1ns / 1ps

module dtti_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  dtti_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output dtti_pkg::item_t pop_item
);
  import dtti_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  // A single-entry queue still needs a one-bit pointer.
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hdl/dtti_front.sv
`timescale 1ns / 1ps

module dtti_front (
  dtti_in_if.sink         in_ch,
  input  logic            signed_mode,
  output logic            push_valid,
  input  logic            push_ready,
  output dtti_pkg::item_t push_item
);
  import dtti_pkg::*;

  logic [7:0] diff;

  assign diff        = in_ch.char_code - CHAR_ZERO;
  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

  always_comb begin
    push_item.last  = in_ch.last_char;
    push_item.digit = diff[3:0];
    if (!in_ch.has_char) begin
      push_item.kind = KIND_NONE;
    end else if (in_ch.char_code >= CHAR_ZERO && in_ch.char_code <= CHAR_NINE) begin
      push_item.kind = KIND_DIGIT;
    end else if (signed_mode && in_ch.char_code == CHAR_MINUS) begin
      // Whether the minus is the first character is decided in the back part.
      push_item.kind = KIND_MINUS;
    end else begin
      push_item.kind = KIND_BAD;
    end
  end

endmodule

FILE: hdl/dtti_back.sv
`timescale 1ns / 1ps

module dtti_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      width_select,
  input  logic            signed_mode,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  dtti_pkg::item_t pop_item,
  dtti_out_if.source      out_ch
);
  import dtti_pkg::*;

  logic [63:0] mag_r, mag_nxt;
  logic        failed_r, failed_nxt;
  logic        negative_r, negative_nxt;
  logic        at_start_r, at_start_nxt;
  logic        seen_r, seen_nxt;

  logic        end_valid_r, end_valid_nxt;
  end_t        end_r, end_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_value_r, out_value_nxt;
  logic        out_ok_r, out_ok_nxt;

  logic        out_free, end_free, do_pop;
  logic [63:0] mag_x10;
  logic        ovf;
  end_t        step;

  logic [63:0] half, umax;
  logic        in_range, fin_ok;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign end_free  = !end_valid_r || out_free;
  assign pop_ready = end_free;
  assign do_pop    = pop_valid && end_free;

  assign mag_x10 = {mag_r[60:0], 3'b000} + {mag_r[62:0], 1'b0} + {60'd0, pop_item.digit};
  assign ovf     = (mag_r > MAX_DIV10) || (mag_r == MAX_DIV10 && pop_item.digit > MAX_MOD10);

  // Parse step for one word from the queue.
  always_comb begin
    step.magnitude  = mag_r;
    step.failed     = failed_r;
    step.negative   = negative_r;
    step.seen_digit = seen_r;
    case (pop_item.kind)
      KIND_MINUS: begin
        if (at_start_r) begin
          step.negative = 1'b1;
        end else begin
          step.failed = 1'b1;
        end
      end
      KIND_DIGIT: begin
        if (ovf) begin
          step.failed = 1'b1;
        end else if (!failed_r) begin
          step.magnitude = mag_x10;
        end
        step.seen_digit = 1'b1;
      end
      KIND_BAD: begin
        step.failed = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mag_nxt       = mag_r;
    failed_nxt    = failed_r;
    negative_nxt  = negative_r;
    at_start_nxt  = at_start_r;
    seen_nxt      = seen_r;
    end_valid_nxt = end_valid_r && !out_free;
    end_nxt       = end_r;
    if (do_pop) begin
      if (pop_item.last) begin
        end_valid_nxt = 1'b1;
        end_nxt       = step;
        mag_nxt       = '0;
        failed_nxt    = 1'b0;
        negative_nxt  = 1'b0;
        at_start_nxt  = 1'b1;
        seen_nxt      = 1'b0;
      end else begin
        mag_nxt      = step.magnitude;
        failed_nxt   = step.failed;
        negative_nxt = step.negative;
        seen_nxt     = step.seen_digit;
        if (pop_item.kind != KIND_NONE) begin
          at_start_nxt = 1'b0;
        end
      end
    end
  end

  // Range check against the configured width, then the result word.
  always_comb begin
    case (width_select)
      WSEL_8: begin
        half = 64'h80;
        umax = 64'hFF;
      end
      WSEL_16: begin
        half = 64'h8000;
        umax = 64'hFFFF;
      end
      WSEL_32: begin
        half = 64'h8000_0000;
        umax = 64'hFFFF_FFFF;
      end
      default: begin
        half = 64'h8000_0000_0000_0000;
        umax = 64'hFFFF_FFFF_FFFF_FFFF;
      end
    endcase
    if (signed_mode) begin
      in_range = end_r.negative ? (end_r.magnitude <= half) : (end_r.magnitude < half);
    end else begin
      in_range = !end_r.negative && (end_r.magnitude <= umax);
    end
    fin_ok = !end_r.failed && end_r.seen_digit && in_range;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_ok_nxt    = out_ok_r;
    if (end_valid_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = fin_ok;
      if (!fin_ok) begin
        out_value_nxt = '0;
      end else if (end_r.negative) begin
        out_value_nxt = 64'd0 - end_r.magnitude;
      end else begin
        out_value_nxt = end_r.magnitude;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r       <= '0;
      failed_r    <= 1'b0;
      negative_r  <= 1'b0;
      at_start_r  <= 1'b1;
      seen_r      <= 1'b0;
      end_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mag_r       <= mag_nxt;
      failed_r    <= failed_nxt;
      negative_r  <= negative_nxt;
      at_start_r  <= at_start_nxt;
      seen_r      <= seen_nxt;
      end_valid_r <= end_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r       <= end_nxt;
    out_value_r <= out_value_nxt;
    out_ok_r    <= out_ok_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;
  assign out_ch.ok    = out_ok_r;

endmodule

FILE: hdl/decimal_text_to_integer.sv
`timescale 1ns / 1ps
// Throughput: one character word per cycle unless out_ch.ready stalls the result.
// A last word waits in the queue behind any words ahead of it, then passes through
// the end register (end_r) and the result register (out_value_r).
// Reset (rst_n, synchronous, active low) empties the queue and the result stage,
// clears the parse state and sets width_select to 32 bits and signed_mode to 0.

module decimal_text_to_integer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  dtti_in_if.sink     in_ch,
  dtti_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dtti_pkg::*;

  logic [1:0] width_select_r, width_select_nxt;
  logic       signed_mode_r, signed_mode_nxt;
  logic       cfg_write;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    width_select_nxt = width_select_r;
    signed_mode_nxt  = signed_mode_r;
    if (cfg_write) begin
      case (paddr[2])
        REG_WIDTH_SELECT: width_select_nxt = pwdata[1:0];
        REG_SIGNED_MODE:  signed_mode_nxt  = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH_SELECT: prdata = {30'd0, width_select_r};
      REG_SIGNED_MODE:  prdata = {31'd0, signed_mode_r};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_select_r <= WIDTH_SELECT_RST;
      signed_mode_r  <= SIGNED_MODE_RST;
    end else begin
      width_select_r <= width_select_nxt;
      signed_mode_r  <= signed_mode_nxt;
    end
  end

  dtti_front u_front (
    .in_ch       (in_ch),
    .signed_mode (signed_mode_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  dtti_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  dtti_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .width_select (width_select_r),
    .signed_mode  (signed_mode_r),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .out_ch       (out_ch)
  );

`ifndef ASSERT_OFF
  // Nothing may come out in the cycle after reset.
  a_no_result_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

  // An unsigned 8-bit result has no bits above the width.
  a_unsigned8_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ok && !signed_mode_r && width_select_r == WSEL_8
    |-> out_ch.value[63:8] == '0)
    else $error("unsigned 8-bit result out of range");

  // A signed 8-bit result is a proper sign extension.
  a_signed8_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ok && signed_mode_r && width_select_r == WSEL_8
    |-> (out_ch.value[63:7] == '0 || out_ch.value[63:7] == '1))
    else $error("signed 8-bit result not sign extended");
`endif

endmodule
